>>> rtl/core/harmonic_spring_periodic_distance_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef HARMONIC_SPRING_PERIODIC_DISTANCE_UNIT_MACROS_SVH
`define HARMONIC_SPRING_PERIODIC_DISTANCE_UNIT_MACROS_SVH

`define HSPD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hspd assertion failed");

`define HSPD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("hspd assertion failed");

`endif

>>> rtl/core/hspd_pkg.sv
package hspd_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned LenW    = 31;
  localparam int unsigned WeightW = 20;
  localparam int unsigned StiffW  = 32;
  localparam int unsigned EnergyW = 47;
  localparam int unsigned ForceW  = 48;
  localparam int unsigned AbsW    = 32;
  localparam int unsigned SqW     = 64;
  localparam int unsigned WsqW    = 84;
  localparam int unsigned SumW    = 86;
  localparam int unsigned RadW    = 72;
  localparam int unsigned RootW   = 36;
  localparam int unsigned SqRemW  = 38;
  localparam int unsigned ProdW   = 62;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned LatAxis = 37;
  localparam int unsigned LatRest = 34;
  localparam int unsigned LatSqrt = RootW;
  localparam int unsigned LatOut  = 5;
  localparam int unsigned Latency = LatAxis + 1 + LatSqrt + LatOut;
  localparam int unsigned RestDly = LatAxis + 1 + LatSqrt - LatRest;

  localparam logic [EnergyW-1:0] EnergyMax   = {EnergyW{1'b1}};
  localparam logic [51:0]        ForcePosMax = 52'h7FFF_FFFF_FFFF;
  localparam logic [51:0]        ForceNegMag = 52'h8000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_STIFFNESS,
    CFG_TARGET_LENGTH,
    CFG_START_LENGTH,
    CFG_RAMP_STEPS,
    CFG_WEIGHT_X,
    CFG_WEIGHT_Y,
    CFG_WEIGHT_Z
  } cfg_idx_e;

  typedef struct packed {
    logic [StiffW-1:0]  half_stiffness;
    logic [LenW-1:0]    target_length;
    logic [LenW-1:0]    start_length;
    logic [LenW-1:0]    ramp_steps;
    logic [WeightW-1:0] weight_x;
    logic [WeightW-1:0] weight_y;
    logic [WeightW-1:0] weight_z;
  } cfg_t;

endpackage

>>> rtl/core/hspd_axis.sv
module hspd_axis (
  input  logic                               clk_i,
  input  logic signed [hspd_pkg::CoordW-1:0] first_i,
  input  logic signed [hspd_pkg::CoordW-1:0] second_i,
  input  logic        [hspd_pkg::LenW-1:0]   box_i,
  input  logic        [hspd_pkg::WeightW-1:0] weight_i,
  output logic        [hspd_pkg::WsqW-1:0]   wsq_o
);
  import hspd_pkg::*;

  logic signed [CoordW:0] diff;
  logic        [CoordW:0] diff_abs;

  logic [AbsW-1:0] a_q   [0:AbsW];
  logic [LenW-1:0] box_q [0:AbsW];
  logic [LenW-1:0] rem_q [0:AbsW];

  logic [AbsW-1:0]       af_q;
  logic [SqW-1:0]        sq_q;
  logic [AbsW+WeightW-1:0] plo_q, phi_q;
  logic [WsqW-1:0]       wsq_q;
  logic [LenW-1:0]       fold_sub;

  assign diff     = {first_i[CoordW-1], first_i} - {second_i[CoordW-1], second_i};
  assign diff_abs = diff[CoordW] ? (CoordW+1)'(-diff) : diff;

  always_ff @(posedge clk_i) begin
    a_q[0]   <= diff_abs[AbsW-1:0];
    box_q[0] <= box_i;
    rem_q[0] <= '0;
  end

  for (genvar i = 0; i < AbsW; i++) begin : g_mod
    logic [LenW:0] cur;
    logic          ge;
    assign cur = {rem_q[i], a_q[i][AbsW-1-i]};
    assign ge  = cur >= {1'b0, box_q[i]};
    always_ff @(posedge clk_i) begin
      a_q[i+1]   <= a_q[i];
      box_q[i+1] <= box_q[i];
      rem_q[i+1] <= ge ? LenW'(cur - {1'b0, box_q[i]}) : cur[LenW-1:0];
    end
  end

  assign fold_sub = box_q[AbsW] - rem_q[AbsW];

  always_ff @(posedge clk_i) begin
    if (box_q[AbsW] == '0) begin
      af_q <= a_q[AbsW];
    end else if (rem_q[AbsW] > (box_q[AbsW] >> 1)) begin
      af_q <= AbsW'(fold_sub);
    end else begin
      af_q <= AbsW'(rem_q[AbsW]);
    end
    sq_q  <= af_q * af_q;
    plo_q <= sq_q[AbsW-1:0] * weight_i;
    phi_q <= sq_q[SqW-1:AbsW] * weight_i;
    wsq_q <= WsqW'(plo_q) + {phi_q, {AbsW{1'b0}}};
  end

  assign wsq_o = wsq_q;

endmodule

>>> rtl/core/hspd_rest.sv
module hspd_rest (
  input  logic                         clk_i,
  input  logic [hspd_pkg::LenW-1:0]    step_i,
  input  hspd_pkg::cfg_t               cfg_i,
  output logic [hspd_pkg::LenW-1:0]    rest_o
);
  import hspd_pkg::*;

  logic            up;
  logic [LenW-1:0] diff;
  logic            ramp_br;

  logic [LenW-1:0]  step_q, diff_q;
  logic             br_q;
  logic [ProdW-1:0] prod;

  logic [ProdW-1:0] p_q   [0:LenW];
  logic [LenW-1:0]  rem_q [0:LenW];
  logic [LenW-1:0]  quo_q [0:LenW];
  logic             b_q   [0:LenW];
  logic [LenW-1:0]  rest_q;

  assign up      = cfg_i.target_length >= cfg_i.start_length;
  assign diff    = up ? cfg_i.target_length - cfg_i.start_length
                      : cfg_i.start_length - cfg_i.target_length;
  assign ramp_br = (cfg_i.ramp_steps != '0) && (step_i < cfg_i.ramp_steps);
  assign prod    = diff_q * step_q;

  always_ff @(posedge clk_i) begin
    step_q   <= step_i;
    diff_q   <= diff;
    br_q     <= ramp_br;
    p_q[0]   <= prod;
    rem_q[0] <= prod[ProdW-1:LenW];
    quo_q[0] <= '0;
    b_q[0]   <= br_q;
  end

  for (genvar i = 0; i < LenW; i++) begin : g_div
    logic [LenW:0] cur;
    logic          ge;
    assign cur = {rem_q[i], p_q[i][LenW-1-i]};
    assign ge  = cur >= {1'b0, cfg_i.ramp_steps};
    always_ff @(posedge clk_i) begin
      p_q[i+1]   <= p_q[i];
      b_q[i+1]   <= b_q[i];
      rem_q[i+1] <= ge ? LenW'(cur - {1'b0, cfg_i.ramp_steps}) : cur[LenW-1:0];
      quo_q[i+1] <= {quo_q[i][LenW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!b_q[LenW]) begin
      rest_q <= cfg_i.target_length;
    end else if (up) begin
      rest_q <= cfg_i.start_length + quo_q[LenW];
    end else begin
      rest_q <= cfg_i.start_length - quo_q[LenW];
    end
  end

  assign rest_o = rest_q;

endmodule

>>> rtl/core/hspd_sqrt.sv
module hspd_sqrt (
  input  logic                        clk_i,
  input  logic [hspd_pkg::RadW-1:0]   rad_i,
  output logic [hspd_pkg::RootW-1:0]  root_o
);
  import hspd_pkg::*;

  logic [SqRemW-1:0] rem_q  [0:RootW-1];
  logic [RootW-1:0]  root_q [0:RootW-1];
  logic [RadW-1:0]   rad_q  [0:RootW-1];

  for (genvar i = 0; i < RootW; i++) begin : g_sq
    logic [SqRemW-1:0] in_rem, cur, trial;
    logic [RootW-1:0]  in_root;
    logic [RadW-1:0]   in_rad;
    logic              ge;
    if (i == 0) begin : g_seed
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_rad  = rad_i;
    end else begin : g_chain
      assign in_rem  = rem_q[i-1];
      assign in_root = root_q[i-1];
      assign in_rad  = rad_q[i-1];
    end
    assign cur   = {in_rem[SqRemW-3:0], in_rad[RadW-1:RadW-2]};
    assign trial = {in_root, 2'b01};
    assign ge    = cur >= trial;
    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? cur - trial : cur;
      root_q[i] <= {in_root[RootW-2:0], ge};
      rad_q[i]  <= {in_rad[RadW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

>>> rtl/core/hspd_out.sv
module hspd_out (
  input  logic                                clk_i,
  input  logic        [hspd_pkg::RootW-1:0]   dist_i,
  input  logic        [hspd_pkg::LenW-1:0]    rest_i,
  input  logic        [hspd_pkg::StiffW-1:0]  hs_i,
  output logic        [hspd_pkg::EnergyW-1:0] energy_o,
  output logic signed [hspd_pkg::ForceW-1:0]  force_o
);
  import hspd_pkg::*;

  localparam int unsigned HalfW = RootW / 2;

  logic signed [RootW+1:0] err;
  logic        [RootW+1:0] err_abs;

  logic [RootW-1:0]        mag_a_q;
  logic                    pos_a_q, pos_b_q, pos_c_q;
  logic [2*HalfW-1:0]      hh_q, hl_q, ll_q;
  logic [StiffW+HalfW-1:0] fl_q, fh_q;
  logic [RadW-1:0]         mag2_q;
  logic [67:0]             fsum;
  logic [51:0]             fr_q;
  logic [55:0]             e0_q, e1_q, e2_q;
  logic [ForceW-1:0]       force_d_q, force_q;
  logic [103:0]            en;
  logic [EnergyW-1:0]      energy_q;
  logic [51:0]             fm;

  assign err     = $signed({2'b00, dist_i}) - $signed({{(RootW+2-LenW){1'b0}}, rest_i});
  assign err_abs = err[RootW+1] ? (RootW+2)'(-err) : err;

  always_ff @(posedge clk_i) begin
    mag_a_q <= err_abs[RootW-1:0];
    pos_a_q <= !err[RootW+1] && (err != '0);
  end

  always_ff @(posedge clk_i) begin
    hh_q    <= mag_a_q[RootW-1:HalfW] * mag_a_q[RootW-1:HalfW];
    hl_q    <= mag_a_q[RootW-1:HalfW] * mag_a_q[HalfW-1:0];
    ll_q    <= mag_a_q[HalfW-1:0] * mag_a_q[HalfW-1:0];
    fl_q    <= hs_i * mag_a_q[HalfW-1:0];
    fh_q    <= hs_i * mag_a_q[RootW-1:HalfW];
    pos_b_q <= pos_a_q;
  end

  assign fsum = 68'(fl_q) + {fh_q, {HalfW{1'b0}}};

  always_ff @(posedge clk_i) begin
    mag2_q  <= {hh_q, {RootW{1'b0}}} + RadW'({hl_q, {(HalfW+1){1'b0}}}) + RadW'(ll_q);
    fr_q    <= fsum[67:16];
    pos_c_q <= pos_b_q;
  end

  always_comb begin
    if (pos_c_q) begin
      fm = (fr_q > ForceNegMag) ? ForceNegMag : fr_q;
    end else begin
      fm = (fr_q > ForcePosMax) ? ForcePosMax : fr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q      <= mag2_q[23:0] * hs_i;
    e1_q      <= mag2_q[47:24] * hs_i;
    e2_q      <= mag2_q[71:48] * hs_i;
    force_d_q <= pos_c_q ? ForceW'(52'd0 - fm) : fm[ForceW-1:0];
  end

  assign en = 104'(e0_q) + 104'({e1_q, 24'd0}) + {e2_q, 48'd0};

  always_ff @(posedge clk_i) begin
    energy_q <= (en[103:79] != '0) ? EnergyMax : en[78:32];
    force_q  <= force_d_q;
  end

  assign energy_o = energy_q;
  assign force_o  = $signed(force_q);

endmodule

>>> rtl/core/harmonic_spring_periodic_distance_unit.sv
// The done strobe rises together with the result word of each accepted start.
// Throughput: one word per cycle; busy never rises and done needs no ready.
// Depth is set by the bit-serial modulo, the root pipeline and the split multipliers.
// Reset clears the configuration registers and the valid pipeline; words in flight drop.
module harmonic_spring_periodic_distance_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_we_i,
  input  logic [hspd_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [hspd_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic        [hspd_pkg::LenW-1:0]    step_number_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  first_x_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  first_y_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  first_z_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  second_x_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  second_y_i,
  input  logic signed [hspd_pkg::CoordW-1:0]  second_z_i,
  input  logic        [hspd_pkg::LenW-1:0]    box_x_i,
  input  logic        [hspd_pkg::LenW-1:0]    box_y_i,
  input  logic        [hspd_pkg::LenW-1:0]    box_z_i,
  output logic        [hspd_pkg::EnergyW-1:0] energy_o,
  output logic signed [hspd_pkg::ForceW-1:0]  force_res_o
);
  import hspd_pkg::*;

  cfg_t               cfg_q;
  logic [Latency-1:0] vld_q;
  logic [WsqW-1:0]    wsq_x, wsq_y, wsq_z;
  logic [SumW-1:0]    sum_q;
  logic [RootW-1:0]   root_dist;
  logic [LenW-1:0]    rest;
  logic [LenW-1:0]    rest_dly_q [0:RestDly-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HALF_STIFFNESS: cfg_q.half_stiffness <= cfg_wdata_i[StiffW-1:0];
        CFG_TARGET_LENGTH:  cfg_q.target_length  <= cfg_wdata_i[LenW-1:0];
        CFG_START_LENGTH:   cfg_q.start_length   <= cfg_wdata_i[LenW-1:0];
        CFG_RAMP_STEPS:     cfg_q.ramp_steps     <= cfg_wdata_i[LenW-1:0];
        CFG_WEIGHT_X:       cfg_q.weight_x       <= cfg_wdata_i[WeightW-1:0];
        CFG_WEIGHT_Y:       cfg_q.weight_y       <= cfg_wdata_i[WeightW-1:0];
        CFG_WEIGHT_Z:       cfg_q.weight_z       <= cfg_wdata_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start && !busy};
    end
  end

  assign busy = 1'b0;
  assign done = vld_q[Latency-1];

  hspd_axis u_axis_x (
    .clk_i, .first_i(first_x_i), .second_i(second_x_i), .box_i(box_x_i),
    .weight_i(cfg_q.weight_x), .wsq_o(wsq_x)
  );

  hspd_axis u_axis_y (
    .clk_i, .first_i(first_y_i), .second_i(second_y_i), .box_i(box_y_i),
    .weight_i(cfg_q.weight_y), .wsq_o(wsq_y)
  );

  hspd_axis u_axis_z (
    .clk_i, .first_i(first_z_i), .second_i(second_z_i), .box_i(box_z_i),
    .weight_i(cfg_q.weight_z), .wsq_o(wsq_z)
  );

  always_ff @(posedge clk_i) begin
    sum_q <= SumW'(wsq_x) + SumW'(wsq_y) + SumW'(wsq_z);
  end

  hspd_sqrt u_sqrt (
    .clk_i, .rad_i(RadW'(sum_q[SumW-1:16])), .root_o(root_dist)
  );

  hspd_rest u_rest (
    .clk_i, .step_i(step_number_i), .cfg_i(cfg_q), .rest_o(rest)
  );

  always_ff @(posedge clk_i) begin
    rest_dly_q[0] <= rest;
    for (int i = 1; i < RestDly; i++) begin
      rest_dly_q[i] <= rest_dly_q[i-1];
    end
  end

  hspd_out u_out (
    .clk_i, .dist_i(root_dist), .rest_i(rest_dly_q[RestDly-1]),
    .hs_i(cfg_q.half_stiffness), .energy_o, .force_o(force_res_o)
  );

endmodule

>>> rtl/core/hspd_checker.sv
`include "harmonic_spring_periodic_distance_unit_macros.svh"

module hspd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done
);
  import hspd_pkg::*;

  `HSPD_ASSERT(a_done_from_start, clk_i, rst_ni, done |-> $past(start && !busy, Latency))
  `HSPD_ASSERT(a_never_blocked, clk_i, rst_ni, start |-> !busy)
  `HSPD_ASSERT_ALWAYS(a_quiet_after_reset, clk_i, $past(!rst_ni) |-> !done)

endmodule

bind harmonic_spring_periodic_distance_unit hspd_checker u_hspd_checker (.*);
